>>> hdl/bcmm_pkg.sv
`timescale 1ns / 1ps
package bcmm_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_INNER   = 8;
    localparam int MAX_COLS    = 8;
    localparam int MAX_BATCH   = 4;
    localparam int STORE_DEPTH = 256;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int EXT_W  = ADDR_W + 1;
    localparam int DIM_W  = 4;
    localparam int BAT_W  = 3;
    localparam int IDX_W  = 3;
    localparam int HALF_W = 16;
    localparam int ELEM_W = 2 * HALF_W;
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = 36;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_LOAD_X  = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // partial products of one complex term
    localparam logic [1:0] PH_RR = 2'd0;
    localparam logic [1:0] PH_II = 2'd1;
    localparam logic [1:0] PH_RI = 2'd2;
    localparam logic [1:0] PH_IR = 2'd3;

    typedef struct packed {
        logic       clear;
        logic       mul_en;
        logic [1:0] phase;
    } mac_ctrl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

>>> hdl/bcmm_store.sv
`timescale 1ns / 1ps
module bcmm_store
    import bcmm_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ELEM_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] mem [STORE_DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bcmm_cmac.sv
`timescale 1ns / 1ps
module bcmm_cmac
    import bcmm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mac_ctrl_t               ctrl,
    input  logic [ELEM_W-1:0]       x_data,
    input  logic [ELEM_W-1:0]       y_data,
    output logic signed [ACC_W-1:0] acc_re,
    output logic signed [ACC_W-1:0] acc_im
);

    logic signed [HALF_W-1:0] xr, xi, yr, yi;
    logic signed [HALF_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0]               tag_reg;
    logic                     pvalid_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;

    assign xr = $signed(x_data[HALF_W-1:0]);
    assign xi = $signed(x_data[ELEM_W-1:HALF_W]);
    assign yr = $signed(y_data[HALF_W-1:0]);
    assign yi = $signed(y_data[ELEM_W-1:HALF_W]);

    assign op_a = (ctrl.phase == PH_RR || ctrl.phase == PH_RI) ? xr : xi;
    assign op_b = (ctrl.phase == PH_RR || ctrl.phase == PH_IR) ? yr : yi;

    // stage 1: the one shared 16x16 multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        tag_reg  <= ctrl.phase;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= ctrl.mul_en;
        end
    end

    assign prod_ext = ACC_W'(prod_reg);

    // stage 2: accumulate, real part takes rr minus ii
    always_ff @(posedge aclk) begin
        priority if (ctrl.clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (pvalid_reg) begin
            unique case (tag_reg)
                PH_RR: acc_re_reg <= acc_re_reg + prod_ext;
                PH_II: acc_re_reg <= acc_re_reg - prod_ext;
                PH_RI: acc_im_reg <= acc_im_reg + prod_ext;
                PH_IR: acc_im_reg <= acc_im_reg + prod_ext;
                default: acc_re_reg <= acc_re_reg;
            endcase
        end else begin
            acc_re_reg <= acc_re_reg;
            acc_im_reg <= acc_im_reg;
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

    a_clear_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |-> !pvalid_reg)
        else $error("accumulator cleared while a product is pending");

endmodule

>>> hdl/batched_complex_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// load beats are accepted while the unit is idle and may come back to back
// a compute beat with inner dimension K walks setup, then per result start, K rounds of read and
// four multiply phases, drain and output; the single shared 16x16 multiplier does four
// partial products per complex term; s_tready is low until the last result is registered
// reset (aresetn low, synchronous) clears the sequencer and output valid, sets dims to 8/8/8/4;
// the element stores are not cleared
module batched_complex_matrix_multiply_unit
    import bcmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // element_index, value_re, value_im, batch_index, zero pad
    input  logic [1:0]  s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // result_re, result_im, out_row, out_col, zero pad
    output logic        m_tlast,
    output logic        m_tuser   // error
);

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;
    localparam logic [1:0] CFG_COLS  = 2'd2;
    localparam logic [1:0] CFG_BATCH = 2'd3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_ERR   = 3'd7;

    logic [DIM_W-1:0] row_cnt_reg, inner_cnt_reg, col_cnt_reg;
    logic [BAT_W-1:0] batch_cnt_reg;
    logic [DIM_W-1:0] rows, inner, cols, nb_wide;
    logic [BAT_W-1:0] nb;
    logic [EXT_W-1:0] x_ext, y_ext;

    logic [ADDR_W-1:0] in_idx;
    logic [ELEM_W-1:0] in_value;
    logic [1:0]        in_batch;
    logic              s_beat, x_we, y_we;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        batch_reg, batch_next;
    logic [IDX_W-1:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] base_x_reg, base_x_next, y_col_reg, y_col_next;
    logic [ADDR_W-1:0] x_ptr_reg, x_ptr_next, y_ptr_reg, y_ptr_next;
    logic              last_k, last_r, last_c;

    logic                    m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]        m_re_reg, m_re_next, m_im_reg, m_im_next;
    logic [IDX_W-1:0]        m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic                    m_last_reg, m_last_next, m_err_reg, m_err_next;
    logic                    out_free;

    mac_ctrl_t               mac_ctrl;
    logic [ELEM_W-1:0]       x_data, y_data;
    logic signed [ACC_W-1:0] acc_re, acc_im;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg   <= DIM_W'(8);
            inner_cnt_reg <= DIM_W'(8);
            col_cnt_reg   <= DIM_W'(8);
            batch_cnt_reg <= BAT_W'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ROWS:  row_cnt_reg   <= cfg_wdata;
                CFG_INNER: inner_cnt_reg <= cfg_wdata;
                CFG_COLS:  col_cnt_reg   <= cfg_wdata;
                CFG_BATCH: batch_cnt_reg <= cfg_wdata[BAT_W-1:0];
                default:   row_cnt_reg   <= row_cnt_reg;
            endcase
        end
    end

    assign rows    = clamp_dim(row_cnt_reg, DIM_W'(MAX_ROWS));
    assign inner   = clamp_dim(inner_cnt_reg, DIM_W'(MAX_INNER));
    assign cols    = clamp_dim(col_cnt_reg, DIM_W'(MAX_COLS));
    assign nb_wide = clamp_dim(DIM_W'(batch_cnt_reg), DIM_W'(MAX_BATCH));
    assign nb      = nb_wide[BAT_W-1:0];

    assign x_ext = EXT_W'(EXT_W'(rows) * EXT_W'(inner) * EXT_W'(nb));
    assign y_ext = EXT_W'(EXT_W'(inner) * EXT_W'(cols) * EXT_W'(nb));

    // input beat
    assign in_idx   = s_tdata[7:0];
    assign in_value = s_tdata[39:8];
    assign in_batch = s_tdata[41:40];
    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    assign x_we = s_beat && (s_tuser == MODE_LOAD_X) && (EXT_W'(in_idx) < x_ext);
    assign y_we = s_beat && (s_tuser == MODE_LOAD_Y) && (EXT_W'(in_idx) < y_ext);

    bcmm_store u_left (
        .aclk  (aclk),
        .we    (x_we),
        .waddr (in_idx),
        .wdata (in_value),
        .raddr (x_ptr_reg),
        .rdata (x_data)
    );

    bcmm_store u_right (
        .aclk  (aclk),
        .we    (y_we),
        .waddr (in_idx),
        .wdata (in_value),
        .raddr (y_ptr_reg),
        .rdata (y_data)
    );

    bcmm_cmac u_cmac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .x_data  (x_data),
        .y_data  (y_data),
        .acc_re  (acc_re),
        .acc_im  (acc_im)
    );

    assign last_k   = (DIM_W'(k_reg) + DIM_W'(1)) == inner;
    assign last_r   = (DIM_W'(r_reg) + DIM_W'(1)) == rows;
    assign last_c   = (DIM_W'(c_reg) + DIM_W'(1)) == cols;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        batch_next   = batch_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        phase_next   = phase_reg;
        base_x_next  = base_x_reg;
        y_col_next   = y_col_reg;
        x_ptr_next   = x_ptr_reg;
        y_ptr_next   = y_ptr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_re_next    = m_re_reg;
        m_im_next    = m_im_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        mac_ctrl     = '{clear: 1'b0, mul_en: 1'b0, phase: phase_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_beat && s_tuser == MODE_COMPUTE) begin
                    batch_next = in_batch;
                    state_next = (BAT_W'(in_batch) < nb) ? S_SETUP : S_ERR;
                end
            end
            S_SETUP: begin
                base_x_next    = ADDR_W'(EXT_W'(rows) * EXT_W'(inner) * EXT_W'(batch_reg));
                y_col_next     = ADDR_W'(EXT_W'(inner) * EXT_W'(cols) * EXT_W'(batch_reg));
                r_next         = '0;
                c_next         = '0;
                mac_ctrl.clear = 1'b1;
                state_next     = S_START;
            end
            S_START: begin
                x_ptr_next = base_x_reg + ADDR_W'(r_reg);
                y_ptr_next = y_col_reg;
                k_next     = '0;
                phase_next = PH_RR;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                phase_next      = phase_reg + 2'd1;
                if (phase_reg == PH_IR) begin
                    x_ptr_next = x_ptr_reg + ADDR_W'(rows);
                    y_ptr_next = y_ptr_reg + ADDR_W'(1);
                    k_next     = k_reg + IDX_W'(1);
                    state_next = last_k ? S_DRAIN : S_READ;
                end
            end
            S_DRAIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_re_next      = acc_re;
                    m_im_next      = acc_im;
                    m_row_next     = r_reg;
                    m_col_next     = c_reg;
                    m_last_next    = last_r && last_c;
                    m_err_next     = 1'b0;
                    mac_ctrl.clear = 1'b1;
                    priority if (last_r && last_c) begin
                        state_next = S_IDLE;
                    end else if (last_r) begin
                        r_next     = '0;
                        c_next     = c_reg + IDX_W'(1);
                        y_col_next = y_col_reg + ADDR_W'(inner);
                        state_next = S_START;
                    end else begin
                        r_next     = r_reg + IDX_W'(1);
                        state_next = S_START;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_re_next    = '0;
                    m_im_next    = '0;
                    m_row_next   = '0;
                    m_col_next   = '0;
                    m_last_next  = 1'b1;
                    m_err_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        batch_reg  <= batch_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        phase_reg  <= phase_next;
        base_x_reg <= base_x_next;
        y_col_reg  <= y_col_next;
        x_ptr_reg  <= x_ptr_next;
        y_ptr_reg  <= y_ptr_next;
        m_re_reg   <= m_re_next;
        m_im_reg   <= m_im_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_col_reg, m_row_reg, m_im_reg, m_re_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error beat without last");

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (!x_we && !y_we))
        else $error("store written during a compute");

    a_busy_until_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> (state_reg != S_IDLE))
        else $error("sequencer idle before the last result");

endmodule
